@@ rtl/core/dhms_pkg.sv @@
// Shared types and constants for the dual H-bridge motor sequencer core.
// No dependencies; all other files of the block refer to this package.
package dhms_pkg;

  localparam int unsigned PauseW  = 16;
  localparam int unsigned RunW    = 22;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned SenseW  = 12;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_UP   = 2'd1,
    REQ_DOWN = 2'd2,
    REQ_STOP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_UP    = 2'd1,
    MODE_DOWN  = 2'd2,
    MODE_PAUSE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_STOP    = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_STALL   = 3'd4
  } event_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REVERSE_PAUSE = 3'd0,
    REG_SAFETY_TIMEOUT = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_GRACE = 3'd3,
    REG_RUN_THRESHOLD = 3'd4
  } reg_idx_t;

  localparam logic [PauseW-1:0]  ReversePauseRst  = 16'd500;
  localparam logic [RunW-1:0]    SafetyTimeoutRst = 22'd60000;
  localparam logic [PeriodW-1:0] SamplePeriodRst  = 16'd1000;
  localparam logic [PauseW-1:0]  GraceRst         = 16'd500;
  localparam logic [SenseW-1:0]  RunThresholdRst  = 12'd1400;

  typedef struct packed {
    logic [PauseW-1:0]  reverse_pause;
    logic [RunW-1:0]    safety_timeout;
    logic [PeriodW-1:0] sample_period;
    logic [PauseW-1:0]  grace;
    logic [SenseW-1:0]  run_threshold;
  } cfg_t;

  // Per-motor decoded request.
  typedef struct packed {
    logic tick;
    logic move;
    logic stop;
    logic down;
  } cmd_t;

  function automatic logic [1:0] bridge_of(mode_t m);
    logic [1:0] b;
    case (m)
      MODE_UP:   b = 2'b01;
      MODE_DOWN: b = 2'b10;
      default:   b = 2'b00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/dual_hbridge_motor_sequencer_core.sv @@
// Top level of the dual H-bridge motor sequencer: request register, two motor
// channels, configuration registers and the result register. Uses dhms_pkg.
//
//   Channel   Direction  Handshake              Payload
//   in        in         in_valid / in_stall    req_type, motor_sel, sense_mv_a, sense_mv_b
//   out       out        out_valid / out_stall  bridge_a/b, mode_a/b, event_a/b
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted request waits in the request register, which feeds the motor update
// logic; the result register takes its output unless a held result stalls it.
// One request is accepted every cycle while the result side keeps up.
// When a held result blocks a full request register, that register holds too and
// in_stall rises. Reset clears motor state and valid flags; config takes its defaults.
module dual_hbridge_motor_sequencer_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic                         motor_sel,
  input  logic [dhms_pkg::SenseW-1:0]  sense_mv_a,
  input  logic [dhms_pkg::SenseW-1:0]  sense_mv_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   bridge_a,
  output logic [1:0]                   bridge_b,
  output logic [1:0]                   mode_a,
  output logic [1:0]                   mode_b,
  output logic [2:0]                   event_a,
  output logic [2:0]                   event_b,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dhms_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [dhms_pkg::RunW-1:0]    cfg_data
);

  logic                        req_full;
  dhms_pkg::req_t              req_q;
  logic                        sel_q;
  logic [dhms_pkg::SenseW-1:0] sense_a_q;
  logic [dhms_pkg::SenseW-1:0] sense_b_q;

  logic             advance;
  logic             in_take;
  dhms_pkg::cfg_t   cfg;
  dhms_pkg::cmd_t   cmd_a;
  dhms_pkg::cmd_t   cmd_b;
  dhms_pkg::mode_t  mode_a_next;
  dhms_pkg::mode_t  mode_b_next;
  dhms_pkg::event_t event_a_next;
  dhms_pkg::event_t event_b_next;

  assign advance   = req_full && !(out_valid && out_stall);
  assign in_stall  = req_full && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (in_take) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_q     <= dhms_pkg::req_t'(req_type);
      sel_q     <= motor_sel;
      sense_a_q <= sense_mv_a;
      sense_b_q <= sense_mv_b;
    end
  end

  always_comb begin
    cmd_a.tick = (req_q == dhms_pkg::REQ_TICK);
    cmd_a.move = ((req_q == dhms_pkg::REQ_UP) || (req_q == dhms_pkg::REQ_DOWN)) && !sel_q;
    cmd_a.stop = (req_q == dhms_pkg::REQ_STOP) && !sel_q;
    cmd_a.down = (req_q == dhms_pkg::REQ_DOWN);
    cmd_b.tick = cmd_a.tick;
    cmd_b.move = ((req_q == dhms_pkg::REQ_UP) || (req_q == dhms_pkg::REQ_DOWN)) && sel_q;
    cmd_b.stop = (req_q == dhms_pkg::REQ_STOP) && sel_q;
    cmd_b.down = cmd_a.down;
  end

  dhms_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dhms_motor u_motor_a (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cmd        (cmd_a),
    .sense      (sense_a_q),
    .cfg        (cfg),
    .mode_next  (mode_a_next),
    .event_next (event_a_next)
  );

  dhms_motor u_motor_b (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cmd        (cmd_b),
    .sense      (sense_b_q),
    .cfg        (cfg),
    .mode_next  (mode_b_next),
    .event_next (event_b_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bridge_a <= dhms_pkg::bridge_of(mode_a_next);
      bridge_b <= dhms_pkg::bridge_of(mode_b_next);
      mode_a   <= mode_a_next;
      mode_b   <= mode_b_next;
      event_a  <= event_a_next;
      event_b  <= event_b_next;
    end
  end

  // The input side only backs up when a held result blocks the request register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (req_full && out_valid && out_stall))
    else $error("in_stall without a blocked result");

  // A request in the request register reaches the result register next cycle
  // unless the result side is stalled.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (req_full && !(out_valid && out_stall)) |=> out_valid)
    else $error("request did not produce a result");

  // A start report on motor A always comes with a driven bridge in a running mode.
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_a == dhms_pkg::EV_START)) |->
      ((mode_a == dhms_pkg::MODE_UP) || (mode_a == dhms_pkg::MODE_DOWN)) && (bridge_a != 2'b00))
    else $error("motor A started without driving its bridge");

  // Any stop report on motor B leaves it stopped with its bridge off.
  a_stop_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((event_b == dhms_pkg::EV_STOP) || (event_b == dhms_pkg::EV_TIMEOUT) ||
                   (event_b == dhms_pkg::EV_STALL))) |->
      ((mode_b == dhms_pkg::MODE_STOP) && (bridge_b == 2'b00)))
    else $error("motor B reported a stop but is still driven");

  // A command addresses one motor, so a stop reported on motor A comes with no event on B.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_a == dhms_pkg::EV_STOP)) |-> (event_b == dhms_pkg::EV_NONE))
    else $error("stop request reported on both motors");

endmodule

@@ rtl/core/dhms_cfg.sv @@
// Configuration register file for the motor sequencer.
// Depends on dhms_pkg for the register index codes and the cfg_t struct.
module dhms_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [dhms_pkg::CfgIdxW-1:0] wr_index,
  input  logic [dhms_pkg::RunW-1:0]    wr_data,
  output dhms_pkg::cfg_t              cfg
);

  dhms_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.reverse_pause  <= dhms_pkg::ReversePauseRst;
      regs.safety_timeout <= dhms_pkg::SafetyTimeoutRst;
      regs.sample_period  <= dhms_pkg::SamplePeriodRst;
      regs.grace          <= dhms_pkg::GraceRst;
      regs.run_threshold  <= dhms_pkg::RunThresholdRst;
    end else if (wr_en) begin
      case (dhms_pkg::reg_idx_t'(wr_index))
        dhms_pkg::REG_REVERSE_PAUSE:  regs.reverse_pause  <= wr_data[dhms_pkg::PauseW-1:0];
        dhms_pkg::REG_SAFETY_TIMEOUT: regs.safety_timeout <= wr_data;
        dhms_pkg::REG_SAMPLE_PERIOD:  regs.sample_period  <= wr_data[dhms_pkg::PeriodW-1:0];
        dhms_pkg::REG_GRACE:          regs.grace          <= wr_data[dhms_pkg::PauseW-1:0];
        dhms_pkg::REG_RUN_THRESHOLD:  regs.run_threshold  <= wr_data[dhms_pkg::SenseW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ rtl/core/dhms_motor.sv @@
// State and per-request update logic for one motor channel.
// Depends on dhms_pkg for the mode, event, command and configuration types.
module dhms_motor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  dhms_pkg::cmd_t              cmd,
  input  logic [dhms_pkg::SenseW-1:0] sense,
  input  dhms_pkg::cfg_t              cfg,
  output dhms_pkg::mode_t             mode_next,
  output dhms_pkg::event_t            event_next
);

  dhms_pkg::mode_t              mode;
  logic                         pend_down;
  logic [dhms_pkg::PauseW-1:0]  pause_count;
  logic [dhms_pkg::RunW-1:0]    run_elapsed;
  logic [dhms_pkg::PeriodW-1:0] sample_phase;

  logic                         pend_down_next;
  logic [dhms_pkg::PauseW-1:0]  pause_count_next;
  logic [dhms_pkg::RunW-1:0]    run_elapsed_next;
  logic [dhms_pkg::PeriodW-1:0] sample_phase_next;

  logic [dhms_pkg::PauseW-1:0]  pause_inc;
  logic [dhms_pkg::RunW-1:0]    run_inc;
  logic [dhms_pkg::PeriodW-1:0] phase_inc;
  dhms_pkg::mode_t              run_mode;

  // Saturating increments.
  assign pause_inc = (&pause_count) ? pause_count : pause_count + 1'b1;
  assign run_inc   = (&run_elapsed) ? run_elapsed : run_elapsed + 1'b1;
  assign phase_inc = (&sample_phase) ? sample_phase : sample_phase + 1'b1;

  always_comb begin
    mode_next         = mode;
    event_next        = dhms_pkg::EV_NONE;
    pend_down_next    = pend_down;
    pause_count_next  = pause_count;
    run_elapsed_next  = run_elapsed;
    sample_phase_next = sample_phase;
    run_mode          = pend_down ? dhms_pkg::MODE_DOWN : dhms_pkg::MODE_UP;

    if (cmd.stop) begin
      mode_next  = dhms_pkg::MODE_STOP;
      event_next = dhms_pkg::EV_STOP;
    end else if (cmd.move) begin
      pend_down_next   = cmd.down;
      pause_count_next = '0;
      mode_next        = dhms_pkg::MODE_PAUSE;
      // With no pause configured the motor starts within the same request.
      if (cfg.reverse_pause == '0) begin
        mode_next         = cmd.down ? dhms_pkg::MODE_DOWN : dhms_pkg::MODE_UP;
        run_elapsed_next  = '0;
        sample_phase_next = '0;
        event_next        = dhms_pkg::EV_START;
      end
    end else if (cmd.tick) begin
      case (mode)
        dhms_pkg::MODE_PAUSE: begin
          pause_count_next = pause_inc;
          if (pause_inc >= cfg.reverse_pause) begin
            mode_next         = run_mode;
            run_elapsed_next  = '0;
            sample_phase_next = '0;
            pause_count_next  = '0;
            event_next        = dhms_pkg::EV_START;
          end
        end
        dhms_pkg::MODE_UP, dhms_pkg::MODE_DOWN: begin
          run_elapsed_next = run_inc;
          if (run_inc >= cfg.safety_timeout) begin
            mode_next  = dhms_pkg::MODE_STOP;
            event_next = dhms_pkg::EV_TIMEOUT;
          end else begin
            sample_phase_next = phase_inc;
            if (phase_inc >= cfg.sample_period) begin
              sample_phase_next = '0;
              if ((run_inc >= {{(dhms_pkg::RunW-dhms_pkg::PauseW){1'b0}}, cfg.grace}) &&
                  (sense < cfg.run_threshold)) begin
                mode_next  = dhms_pkg::MODE_STOP;
                event_next = dhms_pkg::EV_STALL;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= dhms_pkg::MODE_STOP;
      pend_down    <= 1'b0;
      pause_count  <= '0;
      run_elapsed  <= '0;
      sample_phase <= '0;
    end else if (step) begin
      mode         <= mode_next;
      pend_down    <= pend_down_next;
      pause_count  <= pause_count_next;
      run_elapsed  <= run_elapsed_next;
      sample_phase <= sample_phase_next;
    end
  end

endmodule
